// ===== sv/aqrfd_pkg.sv =====
// ----------------------------------------------------------------------------
// aqrfd_pkg: shared definitions of the air quality radio frame decoder
// Register indexes, reset values, status codes, result packing and the
// keyed LFSR digest step used by the decoder.
// ----------------------------------------------------------------------------
package aqrfd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_WHITENING_MASK   = 2'd0;
    localparam logic [1:0] CFG_DIGEST_GENERATOR = 2'd1;
    localparam logic [1:0] CFG_DIGEST_START_KEY = 2'd2;
    localparam logic [1:0] CFG_CHECK_CONSTANT   = 2'd3;

    // Register reset values
    localparam logic [7:0]  WHITENING_MASK_RST   = 8'hAA;
    localparam logic [15:0] DIGEST_GENERATOR_RST = 16'h8810;
    localparam logic [15:0] DIGEST_START_KEY_RST = 16'hBA95;
    localparam logic [15:0] CHECK_CONSTANT_RST   = 16'h6DF1;

    // Frame format
    localparam logic [4:0] FRAME_BYTES  = 5'd25;
    localparam logic [3:0] TYPE_PM      = 4'd8;
    localparam logic [3:0] TYPE_CO2     = 4'd10;
    localparam logic [3:0] NIBBLE_INIT  = 4'hF;
    localparam logic [3:0] BATT_MASK    = 4'h6;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_TYPE    = 2'd2;
    localparam logic [1:0] ST_DIGEST  = 2'd3;

    // Result packing
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic [15:0] sum;
        logic [15:0] key;
    } t_digest;

    // Eight LFSR digest bit steps over one byte, most significant bit first.
    function automatic t_digest digest_byte(input logic [15:0] sum,
                                            input logic [15:0] key,
                                            input logic [15:0] gen,
                                            input logic [7:0]  v);
        t_digest d;
        d.sum = sum;
        d.key = key;
        for (int i = 7; i >= 0; i--) begin
            if (v[3'(i)]) begin
                d.sum = d.sum ^ d.key;
            end
            if (d.key[0]) begin
                d.key = (d.key >> 1) ^ gen;
            end else begin
                d.key = d.key >> 1;
            end
        end
        return d;
    endfunction

    // Four decimal-weighted nibbles, 1000/100/10/1.
    function automatic logic [14:0] four_nibbles(input logic [3:0] a,
                                                 input logic [3:0] b,
                                                 input logic [3:0] c,
                                                 input logic [3:0] d);
        return ({11'd0, a} * 15'd1000) + ({11'd0, b} * 15'd100)
             + ({11'd0, c} * 15'd10) + {11'd0, d};
    endfunction

endpackage

// ===== sv/air_quality_radio_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// air_quality_radio_frame_decoder_unit: 7-in-1 air quality frame decoder
// Dewhitens the raw bytes after the radio sync word, runs the keyed LFSR
// digest and gives one decoded result at the byte marked last.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one raw byte per request in i_s_tdata, i_s_tuser marks the
//   first byte after sync, i_s_tlast the last received byte.
//   Master stream: one decoded result per frame, given only for a request
//   that carried tlast. o_m_tuser holds the sensor kind.
//   Config port: write i_cfg_data to register i_cfg_index while i_cfg_we is
//   high; write only while no frame result is pending.
// Throughput and pipeline
//   One request per cycle, sustained while no result waits on a stalled
//   receiver. A request is held in the input register, then the state update,
//   the eight-step digest, the status checks and the nibble conversion run
//   in a single pass into the result register.
// Reset and stall
//   Reset clears the frame count and digest, loads the register reset
//   values and drops any pending request or result. When the receiver
//   stalls, the result register holds and one more request still enters the
//   input register; the slave side stalls only after that.
// ----------------------------------------------------------------------------
module air_quality_radio_frame_decoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [aqrfd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [aqrfd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // slave stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [aqrfd_pkg::IN_DATA_W-1:0]     i_s_tdata,  // [7:0] raw_byte
    input  logic                                i_s_tuser,  // [0] frame_first
    input  logic                                i_s_tlast,  // frame_last
    // master stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [1:0] status, [17:2] sensor_id, [18] low_batt, [32:19] pm_fine,
    // [33] pm_fine_valid, [47:34] pm_coarse, [48] pm_coarse_valid,
    // [63:49] co2_ppm, [64] co2_valid, [71:65] zero
    output logic [aqrfd_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                                o_m_tuser   // [0] sensor_kind
);

    // ---------------------------------------------------------------- config
    logic [7:0]  r_mask;
    logic [15:0] r_gen;
    logic [15:0] r_start_key;
    logic [15:0] r_check_const;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask        <= aqrfd_pkg::WHITENING_MASK_RST;
            r_gen         <= aqrfd_pkg::DIGEST_GENERATOR_RST;
            r_start_key   <= aqrfd_pkg::DIGEST_START_KEY_RST;
            r_check_const <= aqrfd_pkg::CHECK_CONSTANT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aqrfd_pkg::CFG_WHITENING_MASK:   r_mask        <= i_cfg_data[7:0];
                aqrfd_pkg::CFG_DIGEST_GENERATOR: r_gen         <= i_cfg_data;
                aqrfd_pkg::CFG_DIGEST_START_KEY: r_start_key   <= i_cfg_data;
                aqrfd_pkg::CFG_CHECK_CONSTANT:   r_check_const <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // --------------------------------------------------------- input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       r_in_last;
    logic       r_out_valid;
    logic       advance;

    // Move the held request into the decode pass when the result slot frees.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte  <= i_s_tdata;
            r_in_first <= i_s_tuser;
            r_in_last  <= i_s_tlast;
        end
    end

    // ------------------------------------------------------------ frame state
    logic [4:0]  r_idx, n_idx;
    logic [3:0]  r_type_nib, n_type_nib;
    logic [15:0] r_check_word, n_check_word;
    logic [15:0] r_sum, n_sum;
    logic [15:0] r_key, n_key;
    logic [15:0] r_id, n_id;
    logic [15:0] r_gas, n_gas;
    logic [39:0] r_dust, n_dust;      // dewhitened bytes 10..14, byte 10 highest
    logic [3:0]  r_flag, n_flag;

    logic [4:0]  cur_idx, frm_idx;
    logic [15:0] cur_sum, cur_key, frm_sum, frm_key;
    logic [7:0]  white;
    aqrfd_pkg::t_digest dg;

    always_comb begin
        // restart on the first-byte mark, before the byte is taken in
        cur_idx = r_in_first ? 5'd0 : r_idx;
        cur_sum = r_in_first ? 16'd0 : r_sum;
        cur_key = r_in_first ? r_start_key : r_key;

        white = r_in_byte ^ r_mask;
        dg    = aqrfd_pkg::digest_byte(cur_sum, cur_key, r_gen, white);

        n_type_nib   = r_type_nib;
        n_check_word = r_check_word;
        n_id         = r_id;
        n_gas        = r_gas;
        n_dust       = r_dust;
        n_flag       = r_flag;
        frm_idx      = cur_idx;
        frm_sum      = cur_sum;
        frm_key      = cur_key;

        // drop bytes past the frame length
        if (cur_idx < aqrfd_pkg::FRAME_BYTES) begin
            case (cur_idx)
                5'd0:  n_check_word[15:8] = white;
                5'd1:  n_check_word[7:0]  = white;
                5'd2:  n_id[15:8]         = white;
                5'd3:  n_id[7:0]          = white;
                5'd4:  n_gas[15:8]        = white;
                5'd5:  n_gas[7:0]         = white;
                5'd6:  n_type_nib         = r_in_byte[7:4];  // type before dewhitening
                5'd10: n_dust[39:32]      = white;
                5'd11: n_dust[31:24]      = white;
                5'd12: n_dust[23:16]      = white;
                5'd13: n_dust[15:8]       = white;
                5'd14: n_dust[7:0]        = white;
                5'd15: n_flag             = white[3:0];
                default: begin
                end
            endcase
            // check word bytes stay out of the digest
            if (cur_idx >= 5'd2) begin
                frm_sum = dg.sum;
                frm_key = dg.key;
            end
            frm_idx = cur_idx + 5'd1;
        end

        // restart the count and digest after the last byte
        n_idx = r_in_last ? 5'd0 : frm_idx;
        n_sum = r_in_last ? 16'd0 : frm_sum;
        n_key = r_in_last ? r_start_key : frm_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= 5'd0;
            r_type_nib   <= 4'd0;
            r_check_word <= 16'd0;
            r_sum        <= 16'd0;
            r_key        <= aqrfd_pkg::DIGEST_START_KEY_RST;
            r_id         <= 16'd0;
            r_gas        <= 16'd0;
            r_dust       <= 40'd0;
            r_flag       <= 4'd0;
        end else if (advance) begin
            r_idx        <= n_idx;
            r_type_nib   <= n_type_nib;
            r_check_word <= n_check_word;
            r_sum        <= n_sum;
            r_key        <= n_key;
            r_id         <= n_id;
            r_gas        <= n_gas;
            r_dust       <= n_dust;
            r_flag       <= n_flag;
        end
    end

    // ------------------------------------------------------------ result pass
    logic [1:0]  status;
    logic        kind;
    logic        batt;
    logic [14:0] fine_full, coarse_full, co2_full;
    logic        fine_ok, coarse_ok, co2_ok;
    logic [13:0] fine_val, coarse_val;
    logic [14:0] co2_val;
    logic        fine_vld, coarse_vld, co2_vld;
    logic [aqrfd_pkg::OUT_DATA_W-1:0] n_out_data;

    always_comb begin
        // checked in this order: length, type, digest
        if (frm_idx < aqrfd_pkg::FRAME_BYTES) begin
            status = aqrfd_pkg::ST_SHORT;
        end else if (n_type_nib != aqrfd_pkg::TYPE_PM && n_type_nib != aqrfd_pkg::TYPE_CO2) begin
            status = aqrfd_pkg::ST_TYPE;
        end else if ((n_check_word ^ frm_sum) != r_check_const) begin
            status = aqrfd_pkg::ST_DIGEST;
        end else begin
            status = aqrfd_pkg::ST_OK;
        end

        kind = (n_type_nib == aqrfd_pkg::TYPE_CO2);
        batt = ((n_flag & aqrfd_pkg::BATT_MASK) == aqrfd_pkg::BATT_MASK);

        fine_full   = aqrfd_pkg::four_nibbles(n_dust[35:32], n_dust[31:28],
                                              n_dust[27:24], n_dust[23:20]);
        coarse_full = aqrfd_pkg::four_nibbles(n_dust[19:16], n_dust[15:12],
                                              n_dust[11:8],  n_dust[7:4]);
        co2_full    = aqrfd_pkg::four_nibbles(n_gas[15:12], n_gas[11:8],
                                              n_gas[7:4],   n_gas[3:0]);

        // an init pattern in the leading nibble of a PM value, or in the last nibble of CO2, marks it as not there
        fine_ok   = (n_dust[35:32] != aqrfd_pkg::NIBBLE_INIT);
        coarse_ok = (n_dust[19:16] != aqrfd_pkg::NIBBLE_INIT);
        co2_ok    = (n_gas[3:0]    != aqrfd_pkg::NIBBLE_INIT);

        fine_vld   = (status == aqrfd_pkg::ST_OK) && !kind && fine_ok;
        coarse_vld = (status == aqrfd_pkg::ST_OK) && !kind && coarse_ok;
        co2_vld    = (status == aqrfd_pkg::ST_OK) && kind && co2_ok;

        fine_val   = fine_vld   ? fine_full[13:0]   : 14'd0;
        coarse_val = coarse_vld ? coarse_full[13:0] : 14'd0;
        co2_val    = co2_vld    ? co2_full          : 15'd0;

        n_out_data = '0;
        n_out_data[1:0]   = status;
        if (status == aqrfd_pkg::ST_OK) begin
            n_out_data[17:2] = n_id;
            n_out_data[18]   = batt;
        end
        n_out_data[32:19] = fine_val;
        n_out_data[33]    = fine_vld;
        n_out_data[47:34] = coarse_val;
        n_out_data[48]    = coarse_vld;
        n_out_data[63:49] = co2_val;
        n_out_data[64]    = co2_vld;
    end

    // ------------------------------------------------------- result register
    logic [aqrfd_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                             r_out_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_data <= n_out_data;
            r_out_kind <= (status == aqrfd_pkg::ST_OK) && kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;

endmodule

// ===== sv/aqrfd_checker.sv =====
// ----------------------------------------------------------------------------
// aqrfd_checker: port-level checks of the air quality radio frame decoder
// Watches the stream ports over time and flags handshake, latency and
// result-format slips.
// ----------------------------------------------------------------------------
module aqrfd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic                                i_s_tlast,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [aqrfd_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input logic                                o_m_tuser
);

    // Hold a stalled result and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed or dropped");

    // A new result must trace back to an accepted last byte request.
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && i_s_tlast, 2))
        else $error("result without a last byte request");

    // An empty result slot never back-pressures the slave side.
    a_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("slave stalled with empty result slot");

    // A failed frame carries nothing but its status.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] != aqrfd_pkg::ST_OK)
        |-> (o_m_tdata[aqrfd_pkg::OUT_DATA_W-1:2] == '0) && !o_m_tuser)
        else $error("failed frame with nonzero fields");

endmodule

bind air_quality_radio_frame_decoder_unit aqrfd_checker u_aqrfd_checker (.*);

// ===== dv/air_quality_radio_frame_decoder_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// air_quality_radio_frame_decoder_unit_test: self-checking bench of the decoder
// Streams raw sensor frames into the decoder and predicts every decoded
// result in a scoreboard that keeps its own copy of the frame state, the
// dewhitening and the keyed LFSR digest. Well-formed frames are built with
// a correct check word, mixed with spoiled, short, open and noise frames,
// across several register settings. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module air_quality_radio_frame_decoder_unit_test;

    // One decoded result, field by field.
    typedef struct packed {
        logic [1:0]  status;
        logic        kind;
        logic [15:0] id;
        logic        batt;
        logic [13:0] pm_fine;
        logic        pm_fine_ok;
        logic [13:0] pm_coarse;
        logic        pm_coarse_ok;
        logic [14:0] co2;
        logic        co2_ok;
    } t_aq_reading;

    // Frame decode predictor plus the queue of readings still owed by the block.
    class aq_decode_scoreboard;
        logic [7:0]  mask;
        logic [15:0] gen;
        logic [15:0] start_key;
        logic [15:0] check_k;
        logic [4:0]  byte_count;
        logic [3:0]  type_nib;
        logic [3:0]  flags;
        logic [15:0] check_word;
        logic [15:0] digest;
        logic [15:0] key_now;
        logic [15:0] id_word;
        logic [15:0] gas_word;
        logic [39:0] dust;
        t_aq_reading pending_decodes[$];
        int          errors;
        int          results_seen;
        int          co2_seen;
        int          status_seen[4];

        function new();
            mask       = aqrfd_pkg::WHITENING_MASK_RST;
            gen        = aqrfd_pkg::DIGEST_GENERATOR_RST;
            start_key  = aqrfd_pkg::DIGEST_START_KEY_RST;
            check_k    = aqrfd_pkg::CHECK_CONSTANT_RST;
            type_nib   = '0;
            flags      = '0;
            check_word = '0;
            id_word    = '0;
            gas_word   = '0;
            dust       = '0;
            errors       = 0;
            results_seen = 0;
            co2_seen     = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            restart();
        endfunction

        function void restart();
            byte_count = '0;
            digest     = '0;
            key_now    = start_key;
        endfunction

        function void write_reg(logic [aqrfd_pkg::CFG_IDX_W-1:0] idx,
                                logic [aqrfd_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                aqrfd_pkg::CFG_WHITENING_MASK:   mask      = v[7:0];
                aqrfd_pkg::CFG_DIGEST_GENERATOR: gen       = v;
                aqrfd_pkg::CFG_DIGEST_START_KEY: start_key = v;
                aqrfd_pkg::CFG_CHECK_CONSTANT:   check_k   = v;
                default: ;
            endcase
        endfunction

        // Shift one byte through the keyed LFSR, MSB first; returns {sum, key}.
        function logic [31:0] digest_step(logic [15:0] sum, logic [15:0] key,
                                          logic [15:0] poly, logic [7:0] b);
            int i;
            for (i = 7; i >= 0; i--) begin
                if (b[i]) sum = sum ^ key;
                key = key[0] ? ((key >> 1) ^ poly) : (key >> 1);
            end
            return {sum, key};
        endfunction

        function logic [14:0] weigh(logic [3:0] th, logic [3:0] hu, logic [3:0] te,
                                    logic [3:0] on);
            int v;
            v = int'(th) * 1000 + int'(hu) * 100 + int'(te) * 10 + int'(on);
            return v[14:0];
        endfunction

        // Advance the frame state by one accepted request.
        function void take_byte(logic [7:0] raw, logic first, logic last);
            logic [7:0]  m;
            logic [31:0] dk;
            logic [14:0] v;
            t_aq_reading r;
            int          n;
            if (first) restart();
            if (byte_count < aqrfd_pkg::FRAME_BYTES) begin
                n = int'(byte_count);
                m = raw ^ mask;
                case (n)
                    0:  check_word[15:8] = m;
                    1:  check_word[7:0]  = m;
                    2:  id_word[15:8]    = m;
                    3:  id_word[7:0]     = m;
                    4:  gas_word[15:8]   = m;
                    5:  gas_word[7:0]    = m;
                    6:  type_nib         = raw[7:4];   // taken before dewhitening
                    10, 11, 12, 13, 14: dust[(14 - n) * 8 +: 8] = m;
                    15: flags            = m[3:0];
                    default: ;
                endcase
                if (n >= 2) begin
                    dk      = digest_step(digest, key_now, gen, m);
                    digest  = dk[31:16];
                    key_now = dk[15:0];
                end
                byte_count++;
            end
            if (!last) return;

            r = '0;
            if (byte_count < aqrfd_pkg::FRAME_BYTES)
                r.status = aqrfd_pkg::ST_SHORT;
            else if (type_nib != aqrfd_pkg::TYPE_PM && type_nib != aqrfd_pkg::TYPE_CO2)
                r.status = aqrfd_pkg::ST_TYPE;
            else if ((check_word ^ digest) != check_k)
                r.status = aqrfd_pkg::ST_DIGEST;
            else
                r.status = aqrfd_pkg::ST_OK;
            if (r.status == aqrfd_pkg::ST_OK) begin
                r.kind = (type_nib == aqrfd_pkg::TYPE_CO2);
                r.id   = id_word;
                r.batt = ((flags & aqrfd_pkg::BATT_MASK) == aqrfd_pkg::BATT_MASK);
                if (!r.kind) begin
                    // PM2.5: 10L 11H 11L 12H, PM10: 12L 13H 13L 14H
                    if (dust[35:32] != aqrfd_pkg::NIBBLE_INIT) begin
                        v = weigh(dust[35:32], dust[31:28], dust[27:24], dust[23:20]);
                        r.pm_fine    = v[13:0];
                        r.pm_fine_ok = 1'b1;
                    end
                    if (dust[19:16] != aqrfd_pkg::NIBBLE_INIT) begin
                        v = weigh(dust[19:16], dust[15:12], dust[11:8], dust[7:4]);
                        r.pm_coarse    = v[13:0];
                        r.pm_coarse_ok = 1'b1;
                    end
                end else if (gas_word[3:0] != aqrfd_pkg::NIBBLE_INIT) begin
                    r.co2    = weigh(gas_word[15:12], gas_word[11:8], gas_word[7:4],
                                     gas_word[3:0]);
                    r.co2_ok = 1'b1;
                end
            end
            pending_decodes.push_back(r);
            restart();
        endfunction

        task flag_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task same(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                flag_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                        results_seen, field, got, want));
        endtask

        task match_result(logic [aqrfd_pkg::OUT_DATA_W-1:0] d, logic kind);
            t_aq_reading r;
            if (pending_decodes.size() == 0) begin
                flag_mismatch($sformatf("result with nothing pending, tdata %h", d));
                return;
            end
            r = pending_decodes.pop_front();
            results_seen++;
            status_seen[r.status]++;
            if (r.kind) co2_seen++;
            same("status",          16'(d[1:0]),   16'(r.status));
            same("sensor_kind",     16'(kind),     16'(r.kind));
            same("sensor_id",       d[17:2],       r.id);
            same("low_batt",        16'(d[18]),    16'(r.batt));
            same("pm_fine",         16'(d[32:19]), 16'(r.pm_fine));
            same("pm_fine_valid",   16'(d[33]),    16'(r.pm_fine_ok));
            same("pm_coarse",       16'(d[47:34]), 16'(r.pm_coarse));
            same("pm_coarse_valid", 16'(d[48]),    16'(r.pm_coarse_ok));
            same("co2_ppm",         16'(d[63:49]), 16'(r.co2));
            same("co2_valid",       16'(d[64]),    16'(r.co2_ok));
            same("padding",         16'(d[71:65]), '0);
        endtask

        task drop_leftovers();
            while (pending_decodes.size() != 0) begin
                void'(pending_decodes.pop_front());
                flag_mismatch("expected result never arrived");
            end
        endtask
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [aqrfd_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [aqrfd_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [aqrfd_pkg::IN_DATA_W-1:0]   i_s_tdata;    // [7:0] raw_byte
    logic                              i_s_tuser;    // [0] frame_first
    logic                              i_s_tlast;    // frame_last
    logic                              o_m_tvalid;
    logic                              i_m_tready;
    // [1:0] status, [17:2] sensor_id, [18] low_batt, [32:19] pm_fine,
    // [33] pm_fine_valid, [47:34] pm_coarse, [48] pm_coarse_valid,
    // [63:49] co2_ppm, [64] co2_valid, [71:65] zero
    logic [aqrfd_pkg::OUT_DATA_W-1:0]  o_m_tdata;
    logic                              o_m_tuser;    // [0] sensor_kind

    aq_decode_scoreboard sb = new();
    logic quiet;          // high: neither side idles
    int   n_items;        // counted requests, ignored tail bytes left out
    int   n_settings;

    air_quality_radio_frame_decoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: check each accepted result, then pick the next stall.
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready)
                sb.match_result(o_m_tdata, o_m_tuser);
            i_m_tready <= quiet || ($urandom_range(99) >= 35);
        end
    end

    // Offer one request, idling first at random; hold it until accepted.
    task automatic send_byte(logic [7:0] raw, logic first, logic last);
        while (!quiet && $urandom_range(99) < 35) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= raw;
        i_s_tuser  <= first;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        if (first || sb.byte_count < aqrfd_pkg::FRAME_BYTES) n_items++;
        sb.take_byte(raw, first, last);
    endtask

    // Random bytes; mark the first and the last only where asked.
    task automatic send_bytes(int len, logic first, logic last);
        int n;
        for (n = 0; n < len; n++)
            send_byte(8'($urandom), first && n == 0, last && n == len - 1);
    endtask

    // Build a 25-byte frame of the given type with a matching check word, then
    // append ignored tail bytes and optionally spoil one byte after the fact.
    task automatic send_frame(logic [3:0] tn, logic use_first, int extra, logic spoil);
        logic [7:0]  w [0:31];
        logic [31:0] dk;
        logic [15:0] cw;
        int          n;
        int          len;
        for (n = 2; n < 25; n++) w[n] = 8'($urandom);
        w[6] = {tn, 4'($urandom)} ^ sb.mask;
        // lean on the init pattern and the battery bits more than chance would
        if ($urandom_range(4) == 0) w[10][3:0] = aqrfd_pkg::NIBBLE_INIT;
        if ($urandom_range(4) == 0) w[12][3:0] = aqrfd_pkg::NIBBLE_INIT;
        if ($urandom_range(4) == 0) w[5][3:0]  = aqrfd_pkg::NIBBLE_INIT;
        if ($urandom_range(2) == 0) w[15][2:1] = 2'b11;
        // a frame opened without the first mark starts from the running key
        dk = {16'h0000, use_first ? sb.start_key : sb.key_now};
        for (n = 2; n < 25; n++) dk = sb.digest_step(dk[31:16], dk[15:0], sb.gen, w[n]);
        cw = dk[31:16] ^ sb.check_k;
        w[0] = cw[15:8];
        w[1] = cw[7:0];
        len = 25 + extra;
        for (n = 25; n < len; n++) w[n] = 8'($urandom);
        if (spoil) begin
            n = $urandom_range(24);
            w[n] = w[n] ^ 8'($urandom_range(1, 255));
        end
        for (n = 0; n < len; n++)
            send_byte(w[n] ^ sb.mask, use_first && n == 0, n == len - 1);
    endtask

    // Drop valid, wait for every owed result, then let the pipe empty.
    task automatic settle();
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        while (sb.pending_decodes.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        sb.drop_leftovers();
    endtask

    // Write all four registers on back-to-back edges, enable held high.
    task automatic load_config(logic [7:0] m, logic [15:0] g, logic [15:0] k,
                               logic [15:0] c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= aqrfd_pkg::CFG_WHITENING_MASK;
        i_cfg_data  <= {8'h00, m};
        @(posedge i_clk);
        sb.write_reg(aqrfd_pkg::CFG_WHITENING_MASK, {8'h00, m});
        i_cfg_index <= aqrfd_pkg::CFG_DIGEST_GENERATOR;
        i_cfg_data  <= g;
        @(posedge i_clk);
        sb.write_reg(aqrfd_pkg::CFG_DIGEST_GENERATOR, g);
        i_cfg_index <= aqrfd_pkg::CFG_DIGEST_START_KEY;
        i_cfg_data  <= k;
        @(posedge i_clk);
        sb.write_reg(aqrfd_pkg::CFG_DIGEST_START_KEY, k);
        i_cfg_index <= aqrfd_pkg::CFG_CHECK_CONSTANT;
        i_cfg_data  <= c;
        @(posedge i_clk);
        sb.write_reg(aqrfd_pkg::CFG_CHECK_CONSTANT, c);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int         p;
        int         pick;
        logic [3:0] tn;
        logic       use_first;
        int         extra;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        i_s_tlast   <= 1'b0;
        quiet       <= 1'b0;
        n_items     = 0;
        n_settings  = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, on reset register values: a one-byte frame with both
        // marks, a short frame opened only by the previous frame end, then
        // one good CO2 frame.
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b1);
        send_frame(aqrfd_pkg::TYPE_CO2, 1'b1, 0, 1'b0);
        settle();

        for (p = 0; p < 6; p++) begin
            // Leave a frame open across the register change, finish it after.
            send_bytes(12, 1'b1, 1'b0);
            settle();
            case (p)
                0:       load_config(8'h00, 16'h0000, 16'h0000, 16'h0000);
                1:       load_config(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2:       load_config(aqrfd_pkg::WHITENING_MASK_RST,
                                     aqrfd_pkg::DIGEST_GENERATOR_RST,
                                     aqrfd_pkg::DIGEST_START_KEY_RST,
                                     aqrfd_pkg::CHECK_CONSTANT_RST);
                default: load_config(8'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom));
            endcase
            send_bytes(13, 1'b0, 1'b1);
            quiet <= (p == 2);

            while (n_items < 28 + (p + 1) * 312) begin
                pick = $urandom_range(9);
                tn = (pick < 4) ? aqrfd_pkg::TYPE_PM :
                     (pick < 8) ? aqrfd_pkg::TYPE_CO2 : 4'($urandom);
                use_first = ($urandom_range(9) != 0);
                extra = ($urandom_range(5) == 0) ? $urandom_range(1, 7) : 0;
                pick = $urandom_range(99);
                if (pick < 65)
                    send_frame(tn, use_first, extra, 1'b0);
                else if (pick < 77)
                    send_frame(tn, use_first, extra, 1'b1);
                else if (pick < 87)
                    send_bytes($urandom_range(1, 24), use_first, 1'b1);
                else if (pick < 93)
                    send_bytes($urandom_range(1, 24), use_first, 1'b0);
                else
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), $urandom_range(6) == 0,
                                  $urandom_range(2) == 0);
            end
        end
        settle();

        $display("Covered %0d frame bytes under %0d register settings, %0d results checked",
                 n_items, n_settings, sb.results_seen);
        $display("Status mix: ok %0d, short %0d, bad type %0d, bad digest %0d; CO2 %0d",
                 sb.status_seen[aqrfd_pkg::ST_OK], sb.status_seen[aqrfd_pkg::ST_SHORT],
                 sb.status_seen[aqrfd_pkg::ST_TYPE], sb.status_seen[aqrfd_pkg::ST_DIGEST],
                 sb.co2_seen);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
